// ===== design/gcl_pkg.sv =====
package gcl_pkg;

  // default operand width
  localparam int unsigned GclWidth = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture and order the operands
    logic gcd_start;  // start a remainder step: dividend is big, divisor is small
    logic div_step;   // one restoring division bit
    logic swap;       // euclid move: big <= small, small <= remainder
    logic lcm_start;  // start big / gcd division
    logic mul_start;  // clear the accumulator high half
    logic mul_step;   // one shift-add multiply bit
    logic finish;     // register the result and strobe it
  } gcl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic small_zero;  // current divisor is zero, euclid is done
    logic special;     // lcm follows without division or multiply
  } gcl_status_t;

endpackage

// ===== design/gcl_ctrl.sv =====
module gcl_ctrl import gcl_pkg::*; #(
  parameter int unsigned WIDTH = GclWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  gcl_status_t status_i,
  output gcl_cmd_t    cmd_o
);

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] LastStep = CntW'(WIDTH - 1);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    GCD_DIV,
    SWAP,
    LCM_DIV,
    MUL_INIT,
    MUL,
    DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            last_step;

  assign last_step = (cnt_q == LastStep);
  assign busy      = (state_q != IDLE);

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (start) begin
            state_q <= CHECK;
          end
        end
        CHECK: begin
          cnt_q <= '0;
          if (!status_i.small_zero) begin
            state_q <= GCD_DIV;
          end else if (status_i.special) begin
            state_q <= DONE;
          end else begin
            state_q <= LCM_DIV;
          end
        end
        GCD_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= SWAP;
          end
        end
        SWAP: begin
          state_q <= CHECK;
        end
        LCM_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= MUL_INIT;
          end
        end
        MUL_INIT: begin
          cnt_q   <= '0;
          state_q <= MUL;
        end
        MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= DONE;
          end
        end
        DONE: begin
          state_q <= IDLE;
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o = '0;
    case (state_q)
      IDLE:     cmd_o.load = start;
      CHECK: begin
        cmd_o.gcd_start = !status_i.small_zero;
        cmd_o.lcm_start = status_i.small_zero && !status_i.special;
      end
      GCD_DIV:  cmd_o.div_step = 1'b1;
      SWAP:     cmd_o.swap = 1'b1;
      LCM_DIV:  cmd_o.div_step = 1'b1;
      MUL_INIT: cmd_o.mul_start = 1'b1;
      MUL:      cmd_o.mul_step = 1'b1;
      DONE:     cmd_o.finish = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  // a request moves the controller out of idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == IDLE && start) |=> (state_q == CHECK))
    else $error("request not taken");

  // step counter starts from zero in every division or multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MUL_INIT) |=> (cnt_q == '0))
    else $error("multiply counter not cleared");

  // at most one datapath command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("conflicting datapath commands");

endmodule

// ===== design/gcl_datapath.sv =====
module gcl_datapath import gcl_pkg::*; #(
  parameter int unsigned WIDTH = GclWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] operand_a_i,
  input  logic [WIDTH-1:0] operand_b_i,
  input  gcl_cmd_t         cmd_i,
  output gcl_status_t      status_o,
  output logic             done_o,
  output logic [WIDTH-1:0] gcd_value_o,
  output logic [WIDTH-1:0] lcm_value_o,
  output logic             lcm_overflow_o
);

  // ordered operands kept for the whole request
  logic [WIDTH-1:0] big0_q, small0_q;
  logic             equal_q;
  // euclid pair, big holds the gcd at the end
  logic [WIDTH-1:0] big_q, small_q;
  // shared shift pair: remainder / quotient, or product high / low
  logic [WIDTH-1:0] rem_q, quo_q;
  logic             done_q;
  logic [WIDTH-1:0] gcd_q, lcm_q;
  logic             ovf_q;

  logic             a_lt_b;
  logic [WIDTH:0]   shifted;
  logic             ge;
  logic [WIDTH:0]   diff;
  logic [WIDTH:0]   sum;
  logic             small_one;
  logic             prod_ovf;

  assign a_lt_b = (operand_a_i < operand_b_i);

  // restoring division bit
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign ge      = (shifted >= {1'b0, small_q});
  assign diff    = shifted - {1'b0, small_q};

  // shift-add multiply bit
  assign sum = {1'b0, rem_q} + (quo_q[0] ? {1'b0, small0_q} : '0);

  assign small_one = (small0_q == WIDTH'(1));
  // product of full width reaching all ones saturates
  assign prod_ovf  = (rem_q != '0) || (quo_q == '1);

  assign status_o.small_zero = (small_q == '0);
  assign status_o.special    = equal_q || (small0_q == '0) || small_one;

  // operand and euclid registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      big0_q   <= a_lt_b ? operand_b_i : operand_a_i;
      small0_q <= a_lt_b ? operand_a_i : operand_b_i;
      big_q    <= a_lt_b ? operand_b_i : operand_a_i;
      small_q  <= a_lt_b ? operand_a_i : operand_b_i;
      equal_q  <= (operand_a_i == operand_b_i);
    end else if (cmd_i.swap) begin
      big_q   <= small_q;
      small_q <= rem_q;
    end else if (cmd_i.lcm_start) begin
      small_q <= big_q;
    end
  end

  // shared division and multiply shift pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_start) begin
      rem_q <= '0;
      quo_q <= big_q;
    end else if (cmd_i.lcm_start) begin
      rem_q <= '0;
      quo_q <= big0_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_q <= {quo_q[WIDTH-2:0], ge};
    end else if (cmd_i.mul_start) begin
      rem_q <= '0;
    end else if (cmd_i.mul_step) begin
      rem_q <= sum[WIDTH:1];
      quo_q <= {sum[0], quo_q[WIDTH-1:1]};
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      gcd_q <= big_q;
      ovf_q <= 1'b0;
      if (equal_q) begin
        lcm_q <= big0_q;
      end else if (small0_q == '0) begin
        lcm_q <= '0;
      end else if (small_one) begin
        lcm_q <= big0_q;
      end else if (prod_ovf) begin
        lcm_q <= '1;
        ovf_q <= 1'b1;
      end else begin
        lcm_q <= quo_q;
      end
    end
  end

  assign done_o         = done_q;
  assign gcd_value_o    = gcd_q;
  assign lcm_value_o    = lcm_q;
  assign lcm_overflow_o = ovf_q;

  // a remainder stays below its divisor after every division bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(cmd_i.div_step) && small_q != '0 && !$past(cmd_i.load)) |-> (rem_q < small_q))
    else $error("remainder not below divisor");

  // a finished result is shown for a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // overflow always comes with a saturated multiple
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && lcm_overflow_o) |-> (lcm_value_o == '1))
    else $error("overflow without saturation");

endmodule

// ===== design/gcd_lcm_unit.sv =====
// GCD and LCM of two unsigned WIDTH-bit operands. A request is taken when
// start is high and busy is low; busy then stays high until the result is
// ready, and the result appears on gcd_value_o, lcm_value_o and
// lcm_overflow_o for exactly one cycle with done_o high; the receiver cannot
// stall, so capture it in that cycle. A new request may be issued in the
// cycle the result is shown. A request first runs the euclid remainder
// steps, each followed by a swap; when the lcm follows directly (equal
// operands, a zero or a one) the result follows the euclid steps, and
// otherwise the final big / gcd quotient and its product with the smaller
// operand come next. Every remainder and the final big / gcd quotient
// come from one bit-serial divider, and the product from a shift-add multiplier.
// The lcm saturates to all ones with lcm_overflow_o set when the product
// reaches or exceeds all ones.
module gcd_lcm_unit import gcl_pkg::*; #(
  parameter int unsigned WIDTH = GclWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] operand_a_i,
  input  logic [WIDTH-1:0] operand_b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] gcd_value_o,
  output logic [WIDTH-1:0] lcm_value_o,
  output logic             lcm_overflow_o
);

  gcl_cmd_t    cmd;
  gcl_status_t status;

  // sequencer
  gcl_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  // divider, multiplier and result registers
  gcl_datapath #(
    .WIDTH(WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .done_o        (done_o),
    .gcd_value_o   (gcd_value_o),
    .lcm_value_o   (lcm_value_o),
    .lcm_overflow_o(lcm_overflow_o)
  );

  // an accepted request makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // the result comes right as the block leaves busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $fell(busy))
    else $error("result strobe outside the end of a request");

  // a zero gcd only comes from two zero operands, whose multiple is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && gcd_value_o == '0) |-> (lcm_value_o == '0 && !lcm_overflow_o))
    else $error("zero gcd with nonzero multiple");

endmodule
